// ===== hdl/lsw_pkg.sv =====
// Shared constants and types for the line segment window clipper.
package lsw_pkg;

  // Default build-time sizes.
  localparam int COORD_BITS_DEF     = 16;
  localparam int MAX_CLIP_STEPS_DEF = 4;

  // Window register indexes on the configuration port.
  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_BOTTOM = 2'd1;
  localparam logic [1:0] REG_RIGHT  = 2'd2;
  localparam logic [1:0] REG_TOP    = 2'd3;

  // Window values after reset.
  localparam int RESET_LEFT   = 50;
  localparam int RESET_BOTTOM = 50;
  localparam int RESET_RIGHT  = 100;
  localparam int RESET_TOP    = 100;

  // Region code bit positions.
  localparam int CODE_LEFT_BIT   = 0;
  localparam int CODE_RIGHT_BIT  = 1;
  localparam int CODE_BOTTOM_BIT = 2;
  localparam int CODE_TOP_BIT    = 3;

  typedef logic [3:0] region_t;

endpackage

// ===== hdl/line_segment_window_clipper.sv =====
// Cohen-Sutherland segment clipper against a register-held window, one request at a time.
//
//  channel   handshake              payload
//  -------   ---------------------  ---------------------------------------------------
//  request   start / busy           start_x, start_y, end_x, end_y
//  result    done (one-cycle pulse) accepted, clipped_start_x/_y, clipped_end_x/_y
//  window    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each clip step selects the boundary in ST_TEST, goes through the shared multiplier in
// ST_MUL and the bit-serial restoring divider in ST_DIV, then adds and saturates in ST_UPD.
// A request takes from 0 to MAX_CLIP_STEPS clip steps. The divider sets the rate.
// Reset clears the sequencer and loads the default window. The result pulse cannot be held
// off, and a new request may be taken in the same cycle as the pulse.
module line_segment_window_clipper
  import lsw_pkg::*;
#(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int MAX_CLIP_STEPS = MAX_CLIP_STEPS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  output logic                         done,
  output logic                         accepted,
  output logic signed [COORD_BITS-1:0] clipped_start_x,
  output logic signed [COORD_BITS-1:0] clipped_start_y,
  output logic signed [COORD_BITS-1:0] clipped_end_x,
  output logic signed [COORD_BITS-1:0] clipped_end_y,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_data
);

  localparam int DW         = COORD_BITS + 1;
  localparam int SW         = COORD_BITS + 2;
  localparam int STEP_BITS  = $clog2(MAX_CLIP_STEPS + 1);
  localparam int CNT_BITS   = $clog2(COORD_BITS);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_TEST = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_UPD  = 5'b10000
  } state_t;

  state_t state;

  logic signed [COORD_BITS-1:0] window_left, window_bottom, window_right, window_top;
  logic signed [COORD_BITS-1:0] x0, y0, x1, y1;
  logic [STEP_BITS-1:0]         step_cnt;
  logic [CNT_BITS-1:0]          div_cnt;

  // Operands of the current clip step.
  logic [COORD_BITS-1:0]        mag_a, mag_b, divisor;
  logic                         quot_neg, move_start, clip_y, quot_ovf;
  logic signed [COORD_BITS-1:0] base, boundary;
  logic [COORD_BITS-1:0]        rem, quo;

  region_t c0, c1, co;

  always_comb begin
    c0 = '0;
    c1 = '0;
    c0[CODE_LEFT_BIT]   = x0 < window_left;
    c0[CODE_RIGHT_BIT]  = !(x0 < window_left) && (x0 > window_right);
    c0[CODE_BOTTOM_BIT] = y0 < window_bottom;
    c0[CODE_TOP_BIT]    = !(y0 < window_bottom) && (y0 > window_top);
    c1[CODE_LEFT_BIT]   = x1 < window_left;
    c1[CODE_RIGHT_BIT]  = !(x1 < window_left) && (x1 > window_right);
    c1[CODE_BOTTOM_BIT] = y1 < window_bottom;
    c1[CODE_TOP_BIT]    = !(y1 < window_bottom) && (y1 > window_top);
  end

  logic                        seg_in, seg_out, steps_out;
  logic                        sel_clip_y;
  logic signed [COORD_BITS-1:0] sel_edge, sel_base;
  logic signed [DW-1:0]        diff_d, diff_t, diff_den;

  assign seg_in    = (c0 | c1) == '0;
  assign seg_out   = (c0 & c1) != '0;
  assign steps_out = step_cnt == STEP_BITS'(MAX_CLIP_STEPS);
  assign co        = (c0 != '0) ? c0 : c1;

  always_comb begin
    sel_clip_y = 1'b1;
    priority if (co[CODE_TOP_BIT]) begin
      sel_edge = window_top;
    end else if (co[CODE_BOTTOM_BIT]) begin
      sel_edge = window_bottom;
    end else if (co[CODE_RIGHT_BIT]) begin
      sel_edge   = window_right;
      sel_clip_y = 1'b0;
    end else begin
      sel_edge   = window_left;
      sel_clip_y = 1'b0;
    end
    // The interpolation always starts from the start endpoint.
    if (sel_clip_y) begin
      sel_base = x0;
      diff_d   = DW'(x1) - DW'(x0);
      diff_t   = DW'(sel_edge) - DW'(y0);
      diff_den = DW'(y1) - DW'(y0);
    end else begin
      sel_base = y0;
      diff_d   = DW'(y1) - DW'(y0);
      diff_t   = DW'(sel_edge) - DW'(x0);
      diff_den = DW'(x1) - DW'(x0);
    end
  end

  logic [2*COORD_BITS-1:0] product;
  logic [COORD_BITS:0]     trial;
  logic                    trial_ge;

  assign product  = mag_a * mag_b;
  assign trial    = {rem, quo[COORD_BITS-1]};
  assign trial_ge = trial >= {1'b0, divisor};

  logic [COORD_BITS:0]          quot_mag;
  logic signed [SW-1:0]         quot_signed, sum;
  logic signed [COORD_BITS-1:0] moved;
  logic                         in_range;

  always_comb begin
    quot_mag    = quot_ovf ? {1'b1, {COORD_BITS{1'b0}}} : {1'b0, quo};
    quot_signed = signed'({1'b0, quot_mag});
    if (quot_neg) begin
      quot_signed = -quot_signed;
    end
    sum      = SW'(base) + quot_signed;
    in_range = (sum[SW-1:COORD_BITS-1] == '0) || (sum[SW-1:COORD_BITS-1] == '1);
    if (in_range) begin
      moved = sum[COORD_BITS-1:0];
    end else begin
      moved = sum[SW-1] ? {1'b1, {(COORD_BITS-1){1'b0}}} : {1'b0, {(COORD_BITS-1){1'b1}}};
    end
  end

  assign busy      = state != ST_IDLE;
  // The window only changes while no request is in flight or being taken.
  assign cfg_ready = !busy && !start;

  // Sequencer and window registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      done          <= 1'b0;
      window_left   <= COORD_BITS'(RESET_LEFT);
      window_bottom <= COORD_BITS'(RESET_BOTTOM);
      window_right  <= COORD_BITS'(RESET_RIGHT);
      window_top    <= COORD_BITS'(RESET_TOP);
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_LEFT:   window_left   <= cfg_data;
          REG_BOTTOM: window_bottom <= cfg_data;
          REG_RIGHT:  window_right  <= cfg_data;
          REG_TOP:    window_top    <= cfg_data;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (start) state <= ST_TEST;
        end
        ST_TEST: begin
          if (seg_in || seg_out || steps_out) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            state <= ST_MUL;
          end
        end
        ST_MUL: state <= ST_DIV;
        ST_DIV: begin
          if (div_cnt == CNT_BITS'(COORD_BITS - 1)) state <= ST_UPD;
        end
        ST_UPD: state <= ST_TEST;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath: endpoints, shared multiplier and divider, result registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        x0       <= start_x;
        y0       <= start_y;
        x1       <= end_x;
        y1       <= end_y;
        step_cnt <= '0;
      end
      ST_TEST: begin
        accepted        <= seg_in;
        clipped_start_x <= seg_in ? x0 : '0;
        clipped_start_y <= seg_in ? y0 : '0;
        clipped_end_x   <= seg_in ? x1 : '0;
        clipped_end_y   <= seg_in ? y1 : '0;
        mag_a      <= diff_d[DW-1] ? COORD_BITS'(-diff_d) : COORD_BITS'(diff_d);
        mag_b      <= diff_t[DW-1] ? COORD_BITS'(-diff_t) : COORD_BITS'(diff_t);
        divisor    <= diff_den[DW-1] ? COORD_BITS'(-diff_den) : COORD_BITS'(diff_den);
        quot_neg   <= diff_d[DW-1] ^ diff_t[DW-1] ^ diff_den[DW-1];
        move_start <= c0 != '0;
        clip_y     <= sel_clip_y;
        base       <= sel_base;
        boundary   <= sel_edge;
      end
      ST_MUL: begin
        rem     <= product[2*COORD_BITS-1:COORD_BITS];
        quo     <= product[COORD_BITS-1:0];
        div_cnt <= '0;
      end
      ST_DIV: begin
        // A high half at or above the divisor means the quotient saturates anyway.
        if (div_cnt == '0) quot_ovf <= rem >= divisor;
        rem     <= trial_ge ? COORD_BITS'(trial - {1'b0, divisor}) : trial[COORD_BITS-1:0];
        quo     <= {quo[COORD_BITS-2:0], trial_ge};
        div_cnt <= div_cnt + 1'b1;
      end
      ST_UPD: begin
        step_cnt <= step_cnt + 1'b1;
        if (move_start) begin
          x0 <= clip_y ? moved : boundary;
          y0 <= clip_y ? boundary : moved;
        end else begin
          x1 <= clip_y ? moved : boundary;
          y1 <= clip_y ? boundary : moved;
        end
      end
      default: begin
      end
    endcase
  end

  a_done_after_test: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_TEST))
    else $error("result strobe without a decision cycle");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !accepted) |-> (clipped_start_x == '0 && clipped_start_y == '0 &&
                             clipped_end_x == '0 && clipped_end_y == '0))
    else $error("rejected segment carries nonzero coordinates");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (step_cnt <= STEP_BITS'(MAX_CLIP_STEPS)))
    else $error("clip step count ran past its bound");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("request taken but sequencer did not start");

endmodule

// ===== bench/line_segment_window_clipper_test.sv =====
// Self-checking bench for the segment clipper: random and corner-case segments across window settings.
module line_segment_window_clipper_test;
  import lsw_pkg::*;

  typedef logic signed [COORD_BITS_DEF-1:0] coord_t;

  typedef struct {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } segment_t;

  typedef struct {
    logic   acc;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } clip_t;

  localparam longint COORD_HI    = (longint'(1) << (COORD_BITS_DEF - 1)) - 1;
  localparam longint COORD_LO    = -COORD_HI - 1;
  localparam int     CYCLE_LIMIT = 1000000;
  localparam int     PRINT_LIMIT = 50;

  logic   clk;
  logic   rst = 1'b1;
  logic   start = 1'b0;
  coord_t start_x = '0;
  coord_t start_y = '0;
  coord_t end_x = '0;
  coord_t end_y = '0;
  logic   cfg_valid = 1'b0;
  logic   [1:0] cfg_index = REG_LEFT;
  logic   [COORD_BITS_DEF-1:0] cfg_data = '0;
  logic   busy;
  logic   done;
  logic   accepted;
  coord_t clipped_start_x;
  coord_t clipped_start_y;
  coord_t clipped_end_x;
  coord_t clipped_end_y;
  logic   cfg_ready;

  line_segment_window_clipper uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .start_x(start_x),
    .start_y(start_y),
    .end_x(end_x),
    .end_y(end_y),
    .done(done),
    .accepted(accepted),
    .clipped_start_x(clipped_start_x),
    .clipped_start_y(clipped_start_y),
    .clipped_end_x(clipped_end_x),
    .clipped_end_y(clipped_end_y),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Window as the block should hold it, updated on each accepted register write.
  longint win_left;
  longint win_bottom;
  longint win_right;
  longint win_top;

  // Window bounds the stimulus generator aims around.
  longint aim_x_lo;
  longint aim_x_hi;
  longint aim_y_lo;
  longint aim_y_hi;

  segment_t pending_segments[$];
  clip_t    expected_clips[$];
  int       segments_queued = 0;
  int       clips_seen = 0;
  int       error_count = 0;
  int       idle_pct = 0;
  int       cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic region_t region_of(longint x, longint y);
    region_t code;
    code = '0;
    if (x < win_left)
      code[CODE_LEFT_BIT] = 1'b1;
    else if (x > win_right)
      code[CODE_RIGHT_BIT] = 1'b1;
    if (y < win_bottom)
      code[CODE_BOTTOM_BIT] = 1'b1;
    else if (y > win_top)
      code[CODE_TOP_BIT] = 1'b1;
    return code;
  endfunction

  // Free-axis coordinate where the segment meets a boundary, truncated toward zero.
  function automatic longint cross_at(longint p0, longint dp, longint t, longint den);
    longint quot;
    longint v;
    logic   neg;
    neg = ((dp < 0) != (t < 0)) != (den < 0);
    if (den == 0)
      quot = 0;
    else
      quot = ((dp < 0 ? -dp : dp) * (t < 0 ? -t : t)) / (den < 0 ? -den : den);
    v = p0 + (neg ? -quot : quot);
    if (v > COORD_HI)
      v = COORD_HI;
    else if (v < COORD_LO)
      v = COORD_LO;
    return v;
  endfunction

  function automatic clip_t clip_segment(segment_t seg);
    longint  x0;
    longint  y0;
    longint  x1;
    longint  y1;
    longint  nx;
    longint  ny;
    region_t c0;
    region_t c1;
    region_t co;
    clip_t   res;
    x0 = seg.sx;
    y0 = seg.sy;
    x1 = seg.ex;
    y1 = seg.ey;
    c0 = region_of(x0, y0);
    c1 = region_of(x1, y1);
    res = '{acc: 1'b0, sx: '0, sy: '0, ex: '0, ey: '0};
    for (int n = 0; n <= MAX_CLIP_STEPS_DEF; n++) begin
      if ((c0 | c1) == '0) begin
        res = '{acc: 1'b1, sx: coord_t'(x0), sy: coord_t'(y0),
                ex: coord_t'(x1), ey: coord_t'(y1)};
        break;
      end
      if ((c0 & c1) != '0 || n == MAX_CLIP_STEPS_DEF)
        break;
      co = (c0 != '0) ? c0 : c1;
      if (co[CODE_TOP_BIT]) begin
        ny = win_top;
        nx = cross_at(x0, x1 - x0, win_top - y0, y1 - y0);
      end else if (co[CODE_BOTTOM_BIT]) begin
        ny = win_bottom;
        nx = cross_at(x0, x1 - x0, win_bottom - y0, y1 - y0);
      end else if (co[CODE_RIGHT_BIT]) begin
        nx = win_right;
        ny = cross_at(y0, y1 - y0, win_right - x0, x1 - x0);
      end else begin
        nx = win_left;
        ny = cross_at(y0, y1 - y0, win_left - x0, x1 - x0);
      end
      if (c0 != '0) begin
        x0 = nx;
        y0 = ny;
        c0 = region_of(x0, y0);
      end else begin
        x1 = nx;
        y1 = ny;
        c1 = region_of(x1, y1);
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      win_left   <= RESET_LEFT;
      win_bottom <= RESET_BOTTOM;
      win_right  <= RESET_RIGHT;
      win_top    <= RESET_TOP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LEFT:   win_left   <= $signed(cfg_data);
        REG_BOTTOM: win_bottom <= $signed(cfg_data);
        REG_RIGHT:  win_right  <= $signed(cfg_data);
        REG_TOP:    win_top    <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Request driver: predicts each request as it is taken, then offers the next one.
  always @(posedge clk) begin
    segment_t seg;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        seg = '{sx: start_x, sy: start_y, ex: end_x, ey: end_y};
        expected_clips.push_back(clip_segment(seg));
      end
      if (!start || !busy) begin
        if (pending_segments.size() > 0 && $urandom_range(99) >= idle_pct) begin
          seg = pending_segments.pop_front();
          start   <= 1'b1;
          start_x <= seg.sx;
          start_y <= seg.sy;
          end_x   <= seg.ex;
          end_y   <= seg.ey;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string label, longint want, longint got);
    if (want != got) begin
      error_count++;
      if (error_count <= PRINT_LIMIT)
        $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
    end
  endtask

  // Result monitor.
  always @(posedge clk) begin
    clip_t want;
    if (!rst && done) begin
      clips_seen <= clips_seen + 1;
      if (expected_clips.size() == 0) begin
        error_count++;
        if (error_count <= PRINT_LIMIT)
          $display("%0t: result expected none actual accepted=%0d %0d %0d %0d %0d", $time,
                   accepted, clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y);
      end else begin
        want = expected_clips.pop_front();
        check_field("accepted", want.acc, accepted);
        check_field("clipped_start_x", want.sx, clipped_start_x);
        check_field("clipped_start_y", want.sy, clipped_start_y);
        check_field("clipped_end_x", want.ex, clipped_end_x);
        check_field("clipped_end_y", want.ey, clipped_end_y);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic queue_segment(longint sx, longint sy, longint ex, longint ey);
    pending_segments.push_back('{sx: coord_t'(sx), sy: coord_t'(sy),
                                 ex: coord_t'(ex), ey: coord_t'(ey)});
    segments_queued++;
  endtask

  task automatic wait_drained();
    while (clips_seen != segments_queued || start || busy)
      @(posedge clk);
  endtask

  task automatic write_window_reg(logic [1:0] idx, longint value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= coord_t'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_window(longint l, longint b, longint r, longint t);
    write_window_reg(REG_LEFT, l);
    write_window_reg(REG_BOTTOM, b);
    write_window_reg(REG_RIGHT, r);
    write_window_reg(REG_TOP, t);
    aim_x_lo = (l < r) ? l : r;
    aim_x_hi = (l < r) ? r : l;
    aim_y_lo = (b < t) ? b : t;
    aim_y_hi = (b < t) ? t : b;
  endtask

  // Mostly lands around the window so segments cross its edges; some full-range noise.
  function automatic longint pick_coord(longint lo, longint hi);
    longint v;
    longint w;
    longint margin;
    coord_t any;
    w = hi - lo;
    margin = w / 2 + 8;
    case ($urandom_range(9))
      0, 1: begin
        any = coord_t'($urandom);
        v = any;
      end
      2: begin
        case ($urandom_range(3))
          0: v = lo;
          1: v = hi;
          2: v = lo - 1;
          default: v = hi + 1;
        endcase
      end
      default: v = lo - margin + longint'($urandom_range(w + 2 * margin));
    endcase
    if (v > COORD_HI)
      v = COORD_HI;
    else if (v < COORD_LO)
      v = COORD_LO;
    return v;
  endfunction

  task automatic run_random(int idle, int count);
    longint sx;
    longint sy;
    longint ex;
    longint ey;
    idle_pct = idle;
    for (int i = 0; i < count; i++) begin
      sx = pick_coord(aim_x_lo, aim_x_hi);
      sy = pick_coord(aim_y_lo, aim_y_hi);
      ex = pick_coord(aim_x_lo, aim_x_hi);
      ey = pick_coord(aim_y_lo, aim_y_hi);
      case ($urandom_range(19))
        0: begin
          ex = sx;
          ey = sy;
        end
        1, 2: ey = sy;
        3, 4: ex = sx;
        default: ;
      endcase
      queue_segment(sx, sy, ex, ey);
    end
    wait_drained();
  endtask

  task automatic random_window();
    longint a;
    longint b;
    longint c;
    longint d;
    coord_t r;
    r = coord_t'($urandom);
    a = r;
    b = a + $urandom_range(4000);
    r = coord_t'($urandom);
    c = r;
    d = c + $urandom_range(4000);
    if (b > COORD_HI) b = COORD_HI;
    if (d > COORD_HI) d = COORD_HI;
    // Now and then the window comes out inverted on one axis.
    if ($urandom_range(3) == 0)
      set_window(b, c, a, d);
    else
      set_window(a, c, b, d);
  endtask

  initial begin
    aim_x_lo = RESET_LEFT;
    aim_x_hi = RESET_RIGHT;
    aim_y_lo = RESET_BOTTOM;
    aim_y_hi = RESET_TOP;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Corner cases against the window left by reset.
    idle_pct = 0;
    queue_segment(60, 60, 90, 90);
    queue_segment(0, 0, 40, 200);
    queue_segment(75, 0, 75, 200);
    queue_segment(0, 75, 200, 75);
    queue_segment(75, 75, 75, 300);
    queue_segment(75, 75, 75, -300);
    queue_segment(75, 75, 300, 75);
    queue_segment(75, 75, -300, 75);
    queue_segment(0, 0, 150, 150);
    queue_segment(0, 90, 60, 200);
    queue_segment(COORD_LO, COORD_LO, COORD_HI, COORD_HI);
    queue_segment(COORD_HI, COORD_LO, COORD_LO, COORD_HI);
    queue_segment(50, 50, 100, 100);
    queue_segment(75, 75, 75, 75);
    queue_segment(200, 200, 200, 200);
    queue_segment(COORD_LO, 75, COORD_HI, 80);
    queue_segment(49, 101, 101, 49);
    queue_segment(100, COORD_LO, 50, COORD_HI);
    queue_segment(COORD_HI, COORD_HI, COORD_HI, COORD_HI);
    queue_segment(COORD_LO, COORD_LO, COORD_LO, COORD_LO);
    queue_segment(-1, -1, 101, 151);
    wait_drained();

    run_random(0, 200);
    set_window(-1000, -2000, 3000, 500);
    run_random(76, 200);
    run_random(0, 60);
    set_window(COORD_LO, COORD_LO, COORD_HI, COORD_HI);
    run_random(24, 120);
    set_window(0, 0, 0, 0);
    run_random(0, 150);
    set_window(100, 100, -100, -100);
    run_random(76, 180);
    set_window(32000, COORD_LO, COORD_HI, -32000);
    run_random(24, 180);
    random_window();
    run_random(0, 150);
    random_window();
    run_random(76, 120);
    set_window(COORD_HI, COORD_HI, COORD_LO, COORD_LO);
    run_random(24, 100);
    set_window(-5, -5, 5, 5);
    run_random(0, 120);

    // Any pulse still to come after the last expected one is a failure.
    repeat (100) @(posedge clk);
    if (error_count == 0 && expected_clips.size() == 0) begin
      $display("CHECK OK");
    end else begin
      if (expected_clips.size() != 0)
        $display("%0t: results expected %0d more actual 0", $time, expected_clips.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
